[design/sts_pkg.sv]
// Shared types and constants for the SQL token scanner.
`timescale 1ns / 1ps

package sts_pkg;

    // Longest token text that is streamed is MAX_TEXT-1 bytes.
    localparam int MAX_TEXT   = 2048;
    localparam int TEXT_CNT_W = $clog2(MAX_TEXT);

    // Bundle queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // At most four results come out of one input byte.
    localparam int MAX_RES = 4;
    localparam int RIDX_W  = $clog2(MAX_RES);
    localparam int RCNT_W  = $clog2(MAX_RES + 1);

    // Token kinds.
    localparam logic [3:0] K_EOF    = 4'd0;
    localparam logic [3:0] K_IDENT  = 4'd1;
    localparam logic [3:0] K_NUMBER = 4'd2;
    localparam logic [3:0] K_STRING = 4'd3;
    localparam logic [3:0] K_LPAREN = 4'd4;
    localparam logic [3:0] K_RPAREN = 4'd5;
    localparam logic [3:0] K_COMMA  = 4'd6;
    localparam logic [3:0] K_STAR   = 4'd7;
    localparam logic [3:0] K_SEMI   = 4'd8;
    localparam logic [3:0] K_EQ     = 4'd9;
    localparam logic [3:0] K_NEQ    = 4'd10;
    localparam logic [3:0] K_LT     = 4'd11;
    localparam logic [3:0] K_LTE    = 4'd12;
    localparam logic [3:0] K_GT     = 4'd13;
    localparam logic [3:0] K_GTE    = 4'd14;
    localparam logic [3:0] K_ERROR  = 4'd15;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] text_byte;
        logic       byte_valid;
        logic       token_done;
    } res_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        logic [RCNT_W-1:0]      count;
        res_t [MAX_RES-1:0]     res;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[design/sts_front.sv]
// Front end: byte classification and scan state, at most one bundle of results per byte.
`timescale 1ns / 1ps

module sts_front import sts_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // end_of_text
    input  q_stat_t    q_stat,
    output logic       push,
    output bundle_t    push_data
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_INT     = 4'd2;
    localparam logic [3:0] M_FRAC    = 4'd3;
    localparam logic [3:0] M_STR     = 4'd4;
    localparam logic [3:0] M_QSEEN   = 4'd5;
    localparam logic [3:0] M_MINUS   = 4'd6;
    localparam logic [3:0] M_BANG    = 4'd7;
    localparam logic [3:0] M_LESS    = 4'd8;
    localparam logic [3:0] M_GREATER = 4'd9;
    localparam logic [3:0] M_COMMENT = 4'd10;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;

    localparam logic [TEXT_CNT_W-1:0] CNT_LIMIT = TEXT_CNT_W'(MAX_TEXT - 1);
    localparam logic [TEXT_CNT_W-1:0] CNT_ONE   = TEXT_CNT_W'(1);

    logic [3:0]            mode_reg, mode_next;
    logic                  qd_reg, qd_next;
    logic [TEXT_CNT_W-1:0] cnt_reg, cnt_next;

    logic [7:0] c;
    logic       accept;
    logic       is_dig, is_alp, is_sp, is_idch, is_curq;

    res_t [MAX_RES-1:0] ent;
    logic [RCNT_W-1:0]  n;
    logic               rescan;

    assign c        = s_tdata;
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    assign is_dig  = c inside {[8'h30:8'h39]};
    assign is_alp  = c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    assign is_sp   = c inside {8'h20, [8'h09:8'h0d]};
    assign is_idch = is_dig || is_alp || (c == CH_UNDER);
    assign is_curq = (c == (qd_reg ? CH_DQUOTE : CH_SQUOTE));

    // Results are appended at slot n; no byte can cause more than four.
    always_comb begin
        mode_next = mode_reg;
        qd_next   = qd_reg;
        cnt_next  = cnt_reg;
        ent       = '0;
        n         = '0;
        rescan    = 1'b0;

        if (c != 8'h00) begin
            case (mode_reg)
                M_IDENT: begin
                    if (is_idch) begin
                        if (cnt_next < CNT_LIMIT) begin
                            ent[n[RIDX_W-1:0]] = '{K_IDENT, c, 1'b1, 1'b0};
                            n = n + RCNT_W'(1);
                            cnt_next = cnt_next + CNT_ONE;
                        end
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_IDENT, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_dig || (mode_reg == M_INT && c == CH_DOT)) begin
                        if (cnt_next < CNT_LIMIT) begin
                            ent[n[RIDX_W-1:0]] = '{K_NUMBER, c, 1'b1, 1'b0};
                            n = n + RCNT_W'(1);
                            cnt_next = cnt_next + CNT_ONE;
                        end
                        if (!is_dig) begin
                            mode_next = M_FRAC;
                        end
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_NUMBER, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_STR: begin
                    if (is_curq) begin
                        mode_next = M_QSEEN;
                    end else if (cnt_next < CNT_LIMIT) begin
                        ent[n[RIDX_W-1:0]] = '{K_STRING, c, 1'b1, 1'b0};
                        n = n + RCNT_W'(1);
                        cnt_next = cnt_next + CNT_ONE;
                    end
                end
                M_QSEEN: begin
                    if (is_curq) begin
                        mode_next = M_STR;
                        if (cnt_next < CNT_LIMIT) begin
                            ent[n[RIDX_W-1:0]] = '{K_STRING, c, 1'b1, 1'b0};
                            n = n + RCNT_W'(1);
                            cnt_next = cnt_next + CNT_ONE;
                        end
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_STRING, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (c == CH_MINUS) begin
                        mode_next = M_COMMENT;
                    end else if (is_dig) begin
                        // The pending minus becomes the first character of a number.
                        mode_next = M_INT;
                        ent[0] = '{K_NUMBER, CH_MINUS, 1'b1, 1'b0};
                        ent[1] = '{K_NUMBER, c, 1'b1, 1'b0};
                        n = RCNT_W'(2);
                        cnt_next = TEXT_CNT_W'(2);
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_ERROR, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_BANG: begin
                    if (c == CH_EQ) begin
                        ent[n[RIDX_W-1:0]] = '{K_NEQ, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        mode_next = M_IDLE;
                        cnt_next = '0;
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_ERROR, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_LESS: begin
                    if (c == CH_GT || c == CH_EQ) begin
                        ent[n[RIDX_W-1:0]] = '{(c == CH_GT) ? K_NEQ : K_LTE,
                                               8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        mode_next = M_IDLE;
                        cnt_next = '0;
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_LT, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_GREATER: begin
                    if (c == CH_EQ) begin
                        ent[n[RIDX_W-1:0]] = '{K_GTE, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        mode_next = M_IDLE;
                        cnt_next = '0;
                    end else begin
                        ent[n[RIDX_W-1:0]] = '{K_GT, 8'h00, 1'b0, 1'b1};
                        n = n + RCNT_W'(1);
                        rescan = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        mode_next = M_IDLE;
                    end
                end
                default: begin
                    rescan = 1'b1;
                end
            endcase

            // The byte did not continue the old token, so it starts a new one.
            if (rescan) begin
                mode_next = M_IDLE;
                cnt_next  = '0;
                if (!is_sp) begin
                    case (c)
                        CH_MINUS:  mode_next = M_MINUS;
                        CH_BANG:   mode_next = M_BANG;
                        CH_LT:     mode_next = M_LESS;
                        CH_GT:     mode_next = M_GREATER;
                        CH_SQUOTE, CH_DQUOTE: begin
                            qd_next   = (c == CH_DQUOTE);
                            mode_next = M_STR;
                        end
                        CH_LPAREN, CH_RPAREN, CH_COMMA, CH_STAR, CH_SEMI, CH_EQ: begin
                            ent[n[RIDX_W-1:0]].token_done = 1'b1;
                            case (c)
                                CH_LPAREN: ent[n[RIDX_W-1:0]].token_kind = K_LPAREN;
                                CH_RPAREN: ent[n[RIDX_W-1:0]].token_kind = K_RPAREN;
                                CH_COMMA:  ent[n[RIDX_W-1:0]].token_kind = K_COMMA;
                                CH_STAR:   ent[n[RIDX_W-1:0]].token_kind = K_STAR;
                                CH_SEMI:   ent[n[RIDX_W-1:0]].token_kind = K_SEMI;
                                default:   ent[n[RIDX_W-1:0]].token_kind = K_EQ;
                            endcase
                            n = n + RCNT_W'(1);
                        end
                        default: begin
                            if (is_dig || is_alp || c == CH_UNDER) begin
                                mode_next = is_dig ? M_INT : M_IDENT;
                                ent[n[RIDX_W-1:0]] = '{is_dig ? K_NUMBER : K_IDENT,
                                                       c, 1'b1, 1'b0};
                                cnt_next = CNT_ONE;
                            end else begin
                                ent[n[RIDX_W-1:0]] = '{K_ERROR, 8'h00, 1'b0, 1'b1};
                            end
                            n = n + RCNT_W'(1);
                        end
                    endcase
                end
            end
        end

        // End of text closes whatever is pending, then marks the end.
        if (c == 8'h00 || s_tlast) begin
            case (mode_next)
                M_IDENT: begin
                    ent[n[RIDX_W-1:0]] = '{K_IDENT, 8'h00, 1'b0, 1'b1};
                    n = n + RCNT_W'(1);
                end
                M_INT, M_FRAC: begin
                    ent[n[RIDX_W-1:0]] = '{K_NUMBER, 8'h00, 1'b0, 1'b1};
                    n = n + RCNT_W'(1);
                end
                M_QSEEN: begin
                    ent[n[RIDX_W-1:0]] = '{K_STRING, 8'h00, 1'b0, 1'b1};
                    n = n + RCNT_W'(1);
                end
                M_STR, M_MINUS, M_BANG: begin
                    ent[n[RIDX_W-1:0]] = '{K_ERROR, 8'h00, 1'b0, 1'b1};
                    n = n + RCNT_W'(1);
                end
                M_LESS: begin
                    ent[n[RIDX_W-1:0]] = '{K_LT, 8'h00, 1'b0, 1'b1};
                    n = n + RCNT_W'(1);
                end
                M_GREATER: begin
                    ent[n[RIDX_W-1:0]] = '{K_GT, 8'h00, 1'b0, 1'b1};
                    n = n + RCNT_W'(1);
                end
                default: begin
                end
            endcase
            ent[n[RIDX_W-1:0]] = '{K_EOF, 8'h00, 1'b0, 1'b1};
            n = n + RCNT_W'(1);
            mode_next = M_IDLE;
            cnt_next  = '0;
            qd_next   = 1'b0;
        end
    end

    assign push            = accept && (n != '0);
    assign push_data.count = n;
    assign push_data.res   = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            qd_reg   <= 1'b0;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            qd_reg   <= qd_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[design/sts_queue.sv]
// Short register queue of result bundles between front and back.
`timescale 1ns / 1ps

module sts_queue import sts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output q_stat_t q_stat
);

    bundle_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     cnt_reg, cnt_next;

    assign head         = mem_reg[rptr_reg];
    assign q_stat.full  = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb begin
        wptr_next = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[design/sts_back.sv]
// Back end: walks each bundle and drives one result beat per cycle while the queue holds a bundle and m_tready allows.
`timescale 1ns / 1ps

module sts_back import sts_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  bundle_t    head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // text_byte[7:0]
    output logic [5:0] m_tuser,   // token_kind[3:0], byte_valid[4], token_done[5]
    output logic       m_tlast    // run_last
);

    logic [RIDX_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    res_t              res_reg;
    logic              last_reg;
    logic              load, is_last;
    res_t              cur;

    assign cur     = head.res[idx_reg];
    assign is_last = ({1'b0, idx_reg} == head.count - RCNT_W'(1));
    assign load    = !q_stat.empty && (!valid_reg || m_tready);
    assign pop     = load && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + RIDX_W'(1);
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= cur;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.text_byte;
    assign m_tuser  = {res_reg.token_done, res_reg.byte_valid, res_reg.token_kind};
    assign m_tlast  = last_reg;

endmodule

[design/sql_token_scanner.sv]
// Top level of the byte-serial SQL token scanner.
//
//   Channel | Direction | tdata             | tuser                          | tlast
//   s_      | in        | in_byte[7:0]      | -                              | end_of_text
//   m_      | out       | text_byte[7:0]    | kind[3:0] valid[4] done[5]     | run_last
//
// The input takes one byte per cycle while the queue is not full; each byte yields zero to four result beats.
// The output sends one beat per cycle while m_tready is high, so a byte with k results occupies the
// output for k beats; a four-bundle queue absorbs bursts between the two sides.
// An input beat is written into the queue, and its first result beat is then registered in the back end.
// Reset (aresetn low, synchronous) returns the scanner to idle and empties the queue.
// A stalled output fills the queue, after which s_tready drops.
`timescale 1ns / 1ps

module sql_token_scanner import sts_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // text_byte[7:0]
    output logic [5:0] m_tuser,   // token_kind[3:0], byte_valid[4], token_done[5]
    output logic       m_tlast    // run_last
);

    logic    push, pop;
    bundle_t push_data, head;
    q_stat_t q_stat;

    sts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    sts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    sts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sql_token_scanner_test.sv]
// Self-checking stream testbench for the SQL token scanner, with its own lexer predictor.
`timescale 1ns / 1ps

module sql_token_scanner_test import sts_pkg::*; ();

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_BYTES = 200;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_FRAC, SCAN_STR, SCAN_QSEEN,
        SCAN_MINUS, SCAN_BANG, SCAN_LESS, SCAN_GREATER, SCAN_COMMENT
    } scan_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } src_item_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text;
        logic       valid;
        logic       done;
        logic       last;
    } beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;
    logic       m_tlast;

    src_item_t pending_src[$];
    beat_t     expected_beats[$];
    beat_t     byte_beats[$];

    // Lexer state mirrored by the predictor.
    scan_e       scan_st = SCAN_IDLE;
    bit          quote_dq = 1'b0;
    int unsigned text_cnt = 0;

    int    mismatches = 0;
    int    bytes_sent = 0;
    int    beats_seen = 0;
    int    idle_cycles = 0;
    int    gap_left = 0;
    int    stall_left = 0;
    bit    src_calm = 1'b0;
    bit    sink_calm = 1'b0;
    bit    run_done = 1'b0;
    bit [15:0] kinds_closed = '0;

    sql_token_scanner i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void put_beat(logic [3:0] k, logic [7:0] b, logic v, logic d);
        beat_t bt;
        bt = '{kind: k, text: b, valid: v, done: d, last: 1'b0};
        if (byte_beats.size() < MAX_RES) byte_beats.push_back(bt);
    endfunction

    function automatic void emit_text(logic [3:0] k, logic [7:0] c);
        // Bytes past the text limit are dropped while the token carries on.
        if (text_cnt < MAX_TEXT - 1) begin
            put_beat(k, c, 1'b1, 1'b0);
            text_cnt++;
        end
    endfunction

    function automatic void close_token(logic [3:0] k);
        put_beat(k, 8'h00, 1'b0, 1'b1);
        text_cnt = 0;
        scan_st = SCAN_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c);
        scan_st = SCAN_IDLE;
        text_cnt = 0;
        if (is_space(c)) return;
        case (c)
            CH_MINUS: scan_st = SCAN_MINUS;
            CH_LPAR:  close_token(K_LPAREN);
            CH_RPAR:  close_token(K_RPAREN);
            CH_COMMA: close_token(K_COMMA);
            CH_STAR:  close_token(K_STAR);
            CH_SEMI:  close_token(K_SEMI);
            CH_EQUAL: close_token(K_EQ);
            CH_BANG:  scan_st = SCAN_BANG;
            CH_LESS:  scan_st = SCAN_LESS;
            CH_GREAT: scan_st = SCAN_GREATER;
            CH_SQUOTE, CH_DQUOTE: begin
                quote_dq = (c == CH_DQUOTE);
                scan_st = SCAN_STR;
            end
            default: begin
                if (is_digit(c)) begin
                    scan_st = SCAN_INT;
                    emit_text(K_NUMBER, c);
                end else if (is_alpha(c) || c == CH_UNDER) begin
                    scan_st = SCAN_IDENT;
                    emit_text(K_IDENT, c);
                end else begin
                    close_token(K_ERROR);
                end
            end
        endcase
    endfunction

    function automatic void lex_char(logic [7:0] c);
        logic [7:0] quote;
        bit         rescan;
        quote = quote_dq ? CH_DQUOTE : CH_SQUOTE;
        rescan = 1'b0;
        case (scan_st)
            SCAN_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDER) emit_text(K_IDENT, c);
                else begin close_token(K_IDENT); rescan = 1'b1; end
            end
            SCAN_INT: begin
                if (is_digit(c)) emit_text(K_NUMBER, c);
                else if (c == CH_DOT) begin
                    emit_text(K_NUMBER, c);
                    scan_st = SCAN_FRAC;
                end else begin
                    close_token(K_NUMBER);
                    rescan = 1'b1;
                end
            end
            SCAN_FRAC: begin
                if (is_digit(c)) emit_text(K_NUMBER, c);
                else begin close_token(K_NUMBER); rescan = 1'b1; end
            end
            SCAN_STR: begin
                if (c == quote) scan_st = SCAN_QSEEN;
                else emit_text(K_STRING, c);
            end
            SCAN_QSEEN: begin
                // A doubled quote stands for one quote character.
                if (c == quote) begin
                    emit_text(K_STRING, c);
                    scan_st = SCAN_STR;
                end else begin
                    close_token(K_STRING);
                    rescan = 1'b1;
                end
            end
            SCAN_MINUS: begin
                if (c == CH_MINUS) scan_st = SCAN_COMMENT;
                else if (is_digit(c)) begin
                    scan_st = SCAN_INT;
                    text_cnt = 0;
                    emit_text(K_NUMBER, CH_MINUS);
                    emit_text(K_NUMBER, c);
                end else begin
                    close_token(K_ERROR);
                    rescan = 1'b1;
                end
            end
            SCAN_BANG: begin
                if (c == CH_EQUAL) close_token(K_NEQ);
                else begin close_token(K_ERROR); rescan = 1'b1; end
            end
            SCAN_LESS: begin
                if (c == CH_GREAT) close_token(K_NEQ);
                else if (c == CH_EQUAL) close_token(K_LTE);
                else begin close_token(K_LT); rescan = 1'b1; end
            end
            SCAN_GREATER: begin
                if (c == CH_EQUAL) close_token(K_GTE);
                else begin close_token(K_GT); rescan = 1'b1; end
            end
            SCAN_COMMENT: begin
                if (c == CH_NL) scan_st = SCAN_IDLE;
            end
            default: rescan = 1'b1;
        endcase
        if (rescan) start_token(c);
    endfunction

    function automatic void flush_text();
        case (scan_st)
            SCAN_IDENT:            close_token(K_IDENT);
            SCAN_INT, SCAN_FRAC:   close_token(K_NUMBER);
            SCAN_STR:              close_token(K_ERROR);
            SCAN_QSEEN:            close_token(K_STRING);
            SCAN_MINUS, SCAN_BANG: close_token(K_ERROR);
            SCAN_LESS:             close_token(K_LT);
            SCAN_GREATER:          close_token(K_GT);
            default: ;
        endcase
        put_beat(K_EOF, 8'h00, 1'b0, 1'b1);
        scan_st = SCAN_IDLE;
        text_cnt = 0;
        quote_dq = 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eot);
        byte_beats.delete();
        if (c == CH_NUL) flush_text();
        else begin
            lex_char(c);
            if (eot) flush_text();
        end
        if (byte_beats.size() > 0) byte_beats[byte_beats.size() - 1].last = 1'b1;
        foreach (byte_beats[i]) expected_beats.push_back(byte_beats[i]);
    endfunction

    function automatic void push_byte(logic [7:0] c, logic eot);
        pending_src.push_back('{ch: c, eot: eot});
    endfunction

    function automatic void push_text(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], eot_last && i == s.len() - 1);
    endfunction

    function automatic logic [7:0] pick_ident_char(bit first);
        int unsigned r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + (r - 26));
        if (r == 52) return CH_UNDER;
        return 8'("0" + (r - 53));
    endfunction

    function automatic void push_string_token();
        logic [7:0] quote;
        logic [7:0] c;
        quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        push_byte(quote, 1'b0);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
                push_byte(quote, 1'b0);
                push_byte(quote, 1'b0);
            end else begin
                c = 8'($urandom_range(1, 255));
                push_byte(c == quote ? "z" : c, 1'b0);
            end
        end
        // Now and then the string stays open.
        if ($urandom_range(0, 9) != 0) push_byte(quote, 1'b0);
    endfunction

    function automatic void push_random_statement();
        string ops[$];
        logic [7:0] blanks[$];
        ops = '{"(", ")", ",", "*", ";", "=", "!=", "<>", "<", "<=", ">", ">=", "!", "-"};
        blanks = '{CH_SPACE, 8'd9, CH_NL, 8'd11, 8'd12, 8'd13};
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 7: begin
                    push_byte(pick_ident_char(1'b1), 1'b0);
                    repeat ($urandom_range(0, 5)) push_byte(pick_ident_char(1'b0), 1'b0);
                end
                1, 8: begin
                    if ($urandom_range(0, 2) == 0) push_byte(CH_MINUS, 1'b0);
                    repeat ($urandom_range(1, 4))
                        push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                    if ($urandom_range(0, 1)) begin
                        push_byte(CH_DOT, 1'b0);
                        repeat ($urandom_range(0, 3))
                            push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                    end
                end
                2: push_string_token();
                3, 9: push_text(ops[$urandom_range(0, ops.size() - 1)], 1'b0);
                4: begin
                    push_text("--", 1'b0);
                    repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)), 1'b0);
                    push_byte(CH_NL, 1'b0);
                end
                5: push_byte(8'($urandom_range(1, 255)), 1'b0);
                default: push_byte(blanks[$urandom_range(0, blanks.size() - 1)], 1'b0);
            endcase
            if ($urandom_range(0, 4) != 0) push_byte(CH_SPACE, 1'b0);
        end
        case ($urandom_range(0, 3))
            0: pending_src[pending_src.size() - 1].eot = 1'b1;
            1: push_byte(CH_NUL, 1'b0);
            2: push_byte(CH_NUL, 1'b1);
            default: ;
        endcase
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 8));
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    // Source side: one beat per pending byte, with a random gap after each.
    always @(posedge aclk) begin : source_drv
        src_item_t it;
        logic      nxt_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) gap_left--;
                else if (pending_src.size() > 0) begin
                    it = pending_src.pop_front();
                    nxt_valid = 1'b1;
                    s_tdata <= it.ch;
                    s_tlast <= it.eot;
                    if ($urandom_range(0, 40) == 0) src_calm = !src_calm;
                    gap_left = draw_wait(src_calm);
                end
                s_tvalid <= nxt_valid;
            end
        end
    end

    // Result side: check each beat against the oldest prediction, then stall at random.
    always @(posedge aclk) begin : result_mon
        beat_t got;
        beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{kind: m_tuser[3:0], text: m_tdata, valid: m_tuser[4],
                        done: m_tuser[5], last: m_tlast};
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d byte %02h v%b d%b l%b",
                        got.kind, got.text, got.valid, got.done, got.last));
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "beat %0d: got kind %0d byte %02h v%b d%b l%b, want %0d %02h v%b d%b l%b",
                            beats_seen, got.kind, got.text, got.valid, got.done, got.last,
                            want.kind, want.text, want.valid, want.done, want.last));
                    else if (want.done) kinds_closed[want.kind] = 1'b1;
                end
                if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
                stall_left = draw_wait(sink_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (!run_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("sql_token_scanner_test NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int base;

        // Directed: signed fraction, lone '!', operators, stray high bytes, a string left
        // open at end of text, a comment ending the text, a NUL, then 'a_1>=' ending the text.
        push_text("-7.5!x<>", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_text("'a''b", 1'b1);
        push_text("- --c", 1'b1);
        push_byte(CH_NUL, 1'b0);
        push_text("a_1>=", 1'b1);

        base = pending_src.size();
        while (pending_src.size() < base + RANDOM_BYTES) push_random_statement();
        push_byte(CH_NUL, 1'b1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_src.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        run_done = 1'b1;

        $display("Scanned %0d source bytes into %0d result beats.", bytes_sent, beats_seen);
        $display("Token kinds closed correctly: %0d of 16; mismatches: %0d.",
                 $countones(kinds_closed), mismatches);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("sql_token_scanner_test OK");
        end else begin
            $display("sql_token_scanner_test NOT OK");
        end
        $finish;
    end

endmodule
